>>> rtl/positional_array_list_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the positional array list unit
// Shared property forms for the concurrent checks of the list unit.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pal_pkg.sv
// ---------------------------------------------------------------------------
// Positional array list package
// Sizes, operation and status codes, and the control word of the cell row.
// ---------------------------------------------------------------------------
`default_nettype none

package pal_pkg;

  localparam int DEPTH   = 16;
  localparam int OP_W    = 3;
  localparam int POS_W   = 5;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 3;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CMP_W   = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_GET    = 3'd2,
    OP_UPDATE = 3'd3,
    OP_FIND   = 3'd4,
    OP_CLEAR  = 3'd5,
    OP_LENGTH = 3'd6
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  // Broadcast to every cell of the row in each cycle.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic                     upd;
    logic [IDX_W-1:0]         idx;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] value;
  } row_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/pal_if.sv
// ---------------------------------------------------------------------------
// Positional array list channels
// Valid/ready channels for operation items and result items.
// ---------------------------------------------------------------------------
`default_nettype none

interface pal_in_if;
  import pal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          opcode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);
endinterface

interface pal_out_if;
  import pal_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [POS_W-1:0]         found_position;
  logic [COUNT_W-1:0]       count;
  logic [STAT_W-1:0]        status;

  modport source (output valid, output data, output found_position,
                  output count, output status, input ready);
  modport sink   (input valid, input data, input found_position,
                  input count, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/pal_cell.sv
// ---------------------------------------------------------------------------
// Positional array list cell
// Holds one list entry; loads, shifts from a neighbor or holds, and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_cell (
  input  logic                              clk,
  input  logic [pal_pkg::IDX_W-1:0]         cell_idx,
  input  pal_pkg::row_ctrl_t                ctrl,
  input  logic signed [pal_pkg::DATA_W-1:0] lower_in,
  input  logic signed [pal_pkg::DATA_W-1:0] upper_in,
  output logic signed [pal_pkg::DATA_W-1:0] entry,
  output logic                              match
);
  import pal_pkg::*;

  logic signed [DATA_W-1:0] entry_r;
  logic signed [DATA_W-1:0] entry_nxt;

  // Insert opens a gap at the target by moving higher cells up one place;
  // remove closes it by pulling the upper neighbor down.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.ins) begin
      if (cell_idx == ctrl.idx) begin
        entry_nxt = ctrl.value;
      end else if (cell_idx > ctrl.idx) begin
        entry_nxt = lower_in;
      end
    end else if (ctrl.rem) begin
      if (cell_idx >= ctrl.idx) begin
        entry_nxt = upper_in;
      end
    end else if (ctrl.upd && (cell_idx == ctrl.idx)) begin
      entry_nxt = ctrl.value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;
  assign match = (CNT_W'(cell_idx) < ctrl.count) && (entry_r == ctrl.value);

endmodule

`default_nettype wire

>>> rtl/pal_row.sv
// ---------------------------------------------------------------------------
// Positional array list cell row
// Chains the cells so that each inner cell sees the entries of both neighbors.
// ---------------------------------------------------------------------------
`default_nettype none

module pal_row (
  input  logic                              clk,
  input  pal_pkg::row_ctrl_t                ctrl,
  output logic signed [pal_pkg::DATA_W-1:0] entries [pal_pkg::DEPTH],
  output logic [pal_pkg::DEPTH-1:0]         match
);
  import pal_pkg::*;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] lower_w;
      logic signed [DATA_W-1:0] upper_w;

      // The bottom cell never shifts up and the top cell keeps its own
      // entry on a remove, which only ever lands beyond the live count.
      if (gi == 0) begin : g_bottom
        assign lower_w = ctrl.value;
      end else begin : g_lower
        assign lower_w = entries[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_top
        assign upper_w = entries[gi];
      end else begin : g_upper
        assign upper_w = entries[gi+1];
      end

      pal_cell u_cell (
        .clk      (clk),
        .cell_idx (IDX_W'(gi)),
        .ctrl     (ctrl),
        .lower_in (lower_w),
        .upper_in (upper_w),
        .entry    (entries[gi]),
        .match    (match[gi])
      );
    end
  endgenerate

endmodule

`default_nettype wire

>>> rtl/positional_array_list_unit.sv
// ---------------------------------------------------------------------------
// Positional array list unit
// Ordered list of signed 32-bit entries with insert, remove, get, update,
// find, clear and length operations at 1-based positions.
// ---------------------------------------------------------------------------
// In the cycle of the transfer the whole row of entry cells shifts, loads
// or compares, and the result sits in an output register from the next
// cycle on. A new operation is taken every cycle as long as the result
// register is empty or being drained, so the sustained rate is then one
// item per clock. A failing operation (full, empty, bad position, value
// not found) reports its status and leaves the list unchanged; opcode 7
// returns ok with the current count.
`default_nettype none

`include "positional_array_list_unit_defines.svh"

module positional_array_list_unit (
  input  logic      clk,
  input  logic      rst_n,
  pal_in_if.sink    in_ch,
  pal_out_if.source out_ch
);
  import pal_pkg::*;

  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_nxt;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] data_r;
  logic [POS_W-1:0]         found_r;
  logic [COUNT_W-1:0]       count_r;
  status_t                  status_r;

  logic                     accept;
  logic [CMP_W-1:0]         n_cmp;
  logic [CMP_W-1:0]         p_cmp;
  logic [CMP_W-1:0]         pos_m1;
  logic                     full;
  logic                     empty;
  logic                     ins_pos_ok;
  logic                     pos_ok;
  logic                     hit;
  logic [POS_W-1:0]         hit_pos;
  row_ctrl_t                ctrl;
  status_t                  status_nxt;
  logic signed [DATA_W-1:0] data_nxt;
  logic [POS_W-1:0]         found_nxt;
  logic signed [DATA_W-1:0] entries [DEPTH];
  logic [DEPTH-1:0]         match;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign n_cmp      = CMP_W'(cnt_r);
  assign p_cmp      = CMP_W'(in_ch.position);
  assign pos_m1     = p_cmp - 1'b1;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign empty      = (cnt_r == '0);
  assign ins_pos_ok = (p_cmp != '0) && (p_cmp <= n_cmp + 1'b1);
  assign pos_ok     = (p_cmp != '0) && (p_cmp <= n_cmp);

  pal_row u_row (
    .clk     (clk),
    .ctrl    (ctrl),
    .entries (entries),
    .match   (match)
  );

  // Lowest live cell that matches wins.
  always_comb begin
    hit     = 1'b0;
    hit_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_pos = POS_W'(i + 1);
      end
    end
  end

  always_comb begin
    ctrl       = '0;
    ctrl.idx   = pos_m1[IDX_W-1:0];
    ctrl.count = cnt_r;
    ctrl.value = in_ch.value;
    status_nxt = ST_OK;
    data_nxt   = '0;
    found_nxt  = '0;
    cnt_nxt    = cnt_r;
    unique case (op_t'(in_ch.opcode))
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else if (!ins_pos_ok) begin
          status_nxt = ST_BADPOS;
        end else begin
          ctrl.ins = accept;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end
      OP_REMOVE, OP_GET, OP_UPDATE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!pos_ok) begin
          status_nxt = ST_BADPOS;
        end else if (op_t'(in_ch.opcode) == OP_REMOVE) begin
          ctrl.rem = accept;
          cnt_nxt  = cnt_r - 1'b1;
        end else if (op_t'(in_ch.opcode) == OP_GET) begin
          data_nxt = entries[ctrl.idx];
        end else begin
          ctrl.upd = accept;
        end
      end
      OP_FIND: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (hit) begin
          found_nxt = hit_pos;
        end else begin
          status_nxt = ST_NOTFOUND;
        end
      end
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_LENGTH: begin
        cnt_nxt = cnt_r;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (accept) begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r   <= data_nxt;
      found_r  <= found_nxt;
      count_r  <= COUNT_W'(cnt_nxt);
      status_r <= status_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.data           = data_r;
  assign out_ch.found_position = found_r;
  assign out_ch.count          = count_r;
  assign out_ch.status         = status_r;

  `PAL_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH),
    "entry count exceeds the list depth")
  `PAL_ASSERT_NEXT(a_fail_keeps_count, clk, rst_n, accept && (status_nxt != ST_OK),
    cnt_r == $past(cnt_r), "failed operation changed the entry count")
  `PAL_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.ins,
    cnt_r == CNT_W'($past(cnt_r) + 1'b1), "insert did not grow the list by one")
  `PAL_ASSERT_SAME(a_found_is_ok, clk, rst_n, out_valid_r && (found_r != '0),
    status_r == ST_OK, "found position reported with an error status")

endmodule

`default_nettype wire

>>> verif/positional_array_list_unit_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Positional array list unit testbench
// Drives list operations into the unit and checks every result against a
// behavioral list kept here. Directed tests first: empty list, positions,
// find and a full list. Random phases follow, with and without idle cycles
// on either channel, and a long receiver hold-off that backs up the input.
// ---------------------------------------------------------------------------
module positional_array_list_unit_test;
  import pal_pkg::*;

  localparam logic [OP_W-1:0]          OP_UNUSED   = 3'd7;
  localparam logic signed [DATA_W-1:0] VAL_MIN     = 32'h8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX     = 32'h7fff_ffff;
  localparam int                       CYCLE_LIMIT = 200000;
  localparam int                       MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic [POS_W-1:0]         found_position;
    logic [COUNT_W-1:0]       count;
    logic [STAT_W-1:0]        status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  pal_in_if  in_ch ();
  pal_out_if out_ch ();

  positional_array_list_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #2 clk = ~clk;

  // Behavioral copy of the list.
  logic signed [DATA_W-1:0] list_mem [DEPTH];
  int                       list_len = 0;

  list_result_t expected_results [$];
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           send_idle_pct  = 0;
  int           recv_stall_pct = 0;
  int           hold_off_req   = 0;
  int           hold_left      = 0;

  initial begin
    foreach (list_mem[i]) list_mem[i] = '0;
  end

  function automatic list_result_t predict_list_op(input logic [OP_W-1:0] opcode,
                                                   input logic [POS_W-1:0] position,
                                                   input logic signed [DATA_W-1:0] value);
    list_result_t r;
    int           n;
    int           pos;
    int           i;
    r   = '0;
    n   = list_len;
    pos = position;
    case (opcode)
      OP_INSERT: begin
        if (n >= DEPTH) begin
          r.status = ST_FULL;
        end else if (pos < 1 || pos > n + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = n; i >= pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos-1] = value;
          list_len = n + 1;
        end
      end
      OP_REMOVE, OP_GET, OP_UPDATE: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (pos < 1 || pos > n) begin
          r.status = ST_BADPOS;
        end else if (opcode == OP_REMOVE) begin
          for (i = pos; i < n; i++) list_mem[i-1] = list_mem[i];
          list_len = n - 1;
        end else if (opcode == OP_GET) begin
          r.data = list_mem[pos-1];
        end else begin
          list_mem[pos-1] = value;
        end
      end
      OP_FIND: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.status = ST_NOTFOUND;
          // Scan from the front so that the lowest matching position wins.
          for (i = 0; i < n; i++) begin
            if (r.found_position == '0 && list_mem[i] == value) begin
              r.found_position = POS_W'(i + 1);
              r.status         = ST_OK;
            end
          end
        end
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // Presents one operation and waits for its transfer. Valid stays high on
  // return, so the next call may follow back to back.
  task automatic send_op(input logic [OP_W-1:0] opcode, input logic [POS_W-1:0] position,
                         input logic signed [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= opcode;
    in_ch.position <= position;
    in_ch.value    <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_results.push_back(predict_list_op(opcode, position, value));
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.data           = out_ch.data;
      got.found_position = out_ch.found_position;
      got.count          = out_ch.count;
      got.status         = out_ch.status;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: data %0d pos %0d count %0d st %0d",
                                  got.data, got.found_position, got.count, got.status));
      end else begin
        want = expected_results.pop_front();
        if (got.data !== want.data)
          report_mismatch($sformatf("data exp %0d got %0d", want.data, got.data));
        if (got.found_position !== want.found_position)
          report_mismatch($sformatf("found_position exp %0d got %0d",
                                    want.found_position, got.found_position));
        if (got.count !== want.count)
          report_mismatch($sformatf("count exp %0d got %0d", want.count, got.count));
        if (got.status !== want.status)
          report_mismatch($sformatf("status exp %0d got %0d", want.status, got.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** positional_array_list_unit: FAILED **");
      $finish;
    end
  end

  task automatic send_random_op(input bit grow);
    int                       roll;
    int                       lim;
    int                       small_val;
    logic [OP_W-1:0]          opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
    roll = $urandom_range(99);
    if (grow) begin
      if (roll < 45)      opcode = OP_INSERT;
      else if (roll < 58) opcode = OP_REMOVE;
      else if (roll < 70) opcode = OP_GET;
      else if (roll < 79) opcode = OP_UPDATE;
      else if (roll < 92) opcode = OP_FIND;
      else if (roll < 94) opcode = OP_CLEAR;
      else if (roll < 97) opcode = OP_LENGTH;
      else                opcode = OP_UNUSED;
    end else begin
      if (roll < 15)      opcode = OP_INSERT;
      else if (roll < 50) opcode = OP_REMOVE;
      else if (roll < 65) opcode = OP_GET;
      else if (roll < 75) opcode = OP_UPDATE;
      else if (roll < 90) opcode = OP_FIND;
      else if (roll < 92) opcode = OP_CLEAR;
      else if (roll < 96) opcode = OP_LENGTH;
      else                opcode = OP_UNUSED;
    end
    lim = (opcode == OP_INSERT) ? list_len + 1 : list_len;
    if (lim > 0 && $urandom_range(99) < 85) position = POS_W'($urandom_range(lim, 1));
    else                                    position = POS_W'($urandom_range(31, 0));
    // A narrow pool of small values makes duplicates, and so find hits, common.
    case ($urandom_range(3))
      0: begin
        small_val = int'($urandom_range(7)) - 4;
        value     = small_val;
      end
      1: begin
        case ($urandom_range(3))
          0:       value = VAL_MIN;
          1:       value = VAL_MAX;
          2:       value = '0;
          default: value = '1;
        endcase
      end
      default: value = $urandom;
    endcase
    if (opcode == OP_FIND && list_len > 0 && $urandom_range(99) < 60)
      value = list_mem[$urandom_range(list_len - 1, 0)];
    send_op(opcode, position, value);
  endtask

  task automatic run_random_ops(input int n_items, input int s_idle, input int r_stall);
    int k;
    send_idle_pct  = s_idle;
    recv_stall_pct = r_stall;
    // Alternate between growing and shrinking runs so the list swings
    // between empty and full.
    for (k = 0; k < n_items; k++) send_random_op(((k / 60) % 2) == 0);
    wait_results_drained();
  endtask

  task automatic test_empty_list();
    send_op(OP_GET,    5'd1, '0);
    send_op(OP_REMOVE, 5'd1, '0);
    send_op(OP_UPDATE, 5'd1, VAL_MAX);
    send_op(OP_FIND,   5'd0, '0);
    send_op(OP_UNUSED, 5'd31, '1);
    send_op(OP_INSERT, 5'd2, VAL_MIN);
    send_op(OP_INSERT, 5'd0, VAL_MIN);
  endtask

  task automatic test_positions_and_find();
    send_op(OP_INSERT, 5'd1, VAL_MIN);
    send_op(OP_INSERT, 5'd2, VAL_MAX);
    send_op(OP_INSERT, 5'd1, '1);
    send_op(OP_INSERT, 5'd2, '0);
    send_op(OP_INSERT, 5'd31, VAL_MAX);
    send_op(OP_GET,    5'd4, '0);
    send_op(OP_GET,    5'd5, '0);
    send_op(OP_UPDATE, 5'd1, VAL_MAX);
    send_op(OP_FIND,   5'd0, VAL_MAX);
    send_op(OP_FIND,   5'd0, 32'sd12345);
    send_op(OP_REMOVE, 5'd2, '0);
    send_op(OP_REMOVE, 5'd0, '0);
    send_op(OP_LENGTH, 5'd0, '0);
    send_op(OP_CLEAR,  5'd0, '0);
  endtask

  task automatic test_full_list();
    while (list_len < DEPTH)
      send_op(OP_INSERT, POS_W'($urandom_range(list_len + 1, 1)), $urandom);
    // Full takes precedence over a bad position.
    send_op(OP_INSERT, 5'd17, VAL_MIN);
    send_op(OP_INSERT, 5'd0, VAL_MIN);
    send_op(OP_GET,    5'd16, '0);
    send_op(OP_GET,    5'd17, '0);
    send_op(OP_UPDATE, 5'd16, VAL_MIN);
    send_op(OP_FIND,   5'd0, VAL_MIN);
    send_op(OP_REMOVE, 5'd16, '0);
    send_op(OP_CLEAR,  5'd0, '0);
    wait_results_drained();
  endtask

  task automatic test_random_no_idle();
    run_random_ops(450, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random_ops(450, 49, 0);
  endtask

  task automatic test_random_receiver_stall();
    run_random_ops(450, 0, 49);
  endtask

  task automatic test_random_both_idle();
    run_random_ops(450, 22, 22);
  endtask

  task automatic test_backpressure();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 300;
    for (k = 0; k < 60; k++) send_random_op(k < 30);
    // Hold the input until every outstanding result has come back.
    wait_results_drained();
    for (k = 0; k < 40; k++) send_random_op(1'b1);
    wait_results_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_LENGTH;
    in_ch.position = '0;
    in_ch.value    = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_positions_and_find();
    test_full_list();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_backpressure();
    wait_results_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("** positional_array_list_unit: PASSED **");
    end else begin
      $display("** positional_array_list_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/pal_cell.sv
rtl/pal_row.sv
rtl/positional_array_list_unit.sv
verif/positional_array_list_unit_test.sv
